// ===== hw/rtl/block_buffer_cache_lru_macros.svh =====
// assertion macros used by the buffer cache sequencer
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bbc_pkg.sv =====
// types, constants and command structs for the buffer cache directory
`default_nettype none

package bbc_pkg;

    localparam int BUFFERS_DEF = 32;
    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    // one directory entry apart from its recency rank
    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_rd;
        logic get_commit;
        logic ent_rd;
        logic ent_commit;
        logic sweep_rd;
        logic res_pass;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_get;
        logic idx_ok;
        logic cnt_last;
        logic need_sweep;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/bbc_in_if.sv =====
// request channel: opcode, tag and buffer index
`default_nettype none

interface bbc_in_if import bbc_pkg::*; ();
    logic             valid;
    logic             ready;
    t_op              opcode;
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
    logic [IDX_W-1:0] buffer_index;

    modport source (output valid, output opcode, output device, output block_number,
                    output buffer_index, input ready);
    modport sink   (input valid, input opcode, input device, input block_number,
                    input buffer_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bbc_out_if.sv =====
// result channel: granted buffer and status
`default_nettype none

interface bbc_out_if import bbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] granted_index;
    logic             was_hit;
    logic             need_read;
    t_status          status;

    modport source (output valid, output granted_index, output was_hit, output need_read,
                    output status, input ready);
    modport sink   (input valid, input granted_index, input was_hit, input need_read,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bbc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_ctrl.sv =====
// sequencer for clearing, get scan, count update and recency sweep
`default_nettype none
`include "block_buffer_cache_lru_macros.svh"

module bbc_ctrl import bbc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_SCAN_W,
        S_GDEC,
        S_ERD,
        S_EMOD,
        S_SWEEP,
        S_SWEEP_W,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_res_load;
    t_cmd   w_cmd;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_get) begin
                    n_state = S_SCAN;
                end else if (!i_stat.idx_ok) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_SCAN: begin
                w_cmd.scan_rd = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_SCAN_W;
                end
            end
            S_SCAN_W: begin
                n_state = S_GDEC;
            end
            S_GDEC: begin
                if (w_out_free) begin
                    w_cmd.get_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_ERD: begin
                w_cmd.ent_rd = 1'b1;
                n_state      = S_EMOD;
            end
            S_EMOD: begin
                if (w_out_free) begin
                    w_cmd.ent_commit = 1'b1;
                    n_state          = i_stat.need_sweep ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                w_cmd.sweep_rd = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_SWEEP_W;
                end
            end
            S_SWEEP_W: begin
                n_state = S_IDLE;
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_cmd.res_pass = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_res_load  = w_cmd.get_commit || w_cmd.ent_commit || w_cmd.res_pass;
    assign n_out_valid = w_res_load || (r_out_valid && !i_out_ready);

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    `BBC_ASSERT_NXT(a_accept_disp, i_in_valid && o_in_ready, r_state == S_DISP, "no dispatch")
    `BBC_ASSERT_IMP(a_no_overwrite, w_res_load, !r_out_valid || i_out_ready, "beat overwritten")
    `BBC_ASSERT_IMP(a_rose_commit, $rose(r_out_valid), $past(w_res_load), "beat without commit")

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_dpath.sv =====
// directory storage, tag scan, count update and rank sweep
`default_nettype none

module bbc_dpath import bbc_pkg::*; #(
    parameter int BUFFERS = BUFFERS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    input  wire t_op              i_opcode,
    input  wire logic [DEV_W-1:0] i_device,
    input  wire logic [BLK_W-1:0] i_block_number,
    input  wire logic [IDX_W-1:0] i_buffer_index,
    output logic      [IDX_W-1:0] o_granted_index,
    output logic                  o_was_hit,
    output logic                  o_need_read,
    output t_status               o_status
);

    localparam int IW = $clog2(BUFFERS);
    localparam logic [IW-1:0] LAST = IW'(BUFFERS - 1);

    // request fields
    t_op              r_op;
    logic [DEV_W-1:0] r_dev;
    logic [BLK_W-1:0] r_blk;
    logic [IDX_W-1:0] r_idx;
    logic [IW-1:0]    w_idx_a;

    // sequencing
    logic [IW-1:0] r_cnt;
    logic          r_pv;
    logic [IW-1:0] r_pa;
    logic          r_sv;
    logic [IW-1:0] r_sa;

    // scan results
    logic          r_found;
    logic          r_got;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_rank;
    t_entry        r_hit_ent;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_free_rank;
    logic [IW-1:0] r_old_rank;

    // result register
    logic [IDX_W-1:0] r_res_idx;
    logic             r_res_hit;
    logic             r_res_rd;
    t_status          r_res_st;

    // ram ports
    logic          w_re;
    logic [IW-1:0] w_raddr;
    t_entry        w_e_q;
    logic [IW-1:0] w_k_q;
    logic          w_e_we;
    logic [IW-1:0] w_e_wa;
    t_entry        w_e_wd;
    logic          w_k_we;
    logic [IW-1:0] w_k_wa;
    logic [IW-1:0] w_k_wd;

    // scan compare
    logic w_match;
    logic w_take_hit;
    logic w_take_free;

    // single entry update
    logic w_is_pin;
    logic w_sat;
    logic w_zero;
    logic w_hit_sat;

    assign w_idx_a  = IW'(r_idx);
    assign w_re     = i_cmd.scan_rd || i_cmd.ent_rd || i_cmd.sweep_rd;
    assign w_raddr  = i_cmd.ent_rd ? w_idx_a : r_cnt;

    assign w_match     = (w_e_q.dev == r_dev) && (w_e_q.blk == r_blk);
    assign w_take_hit  = r_pv && w_match && (!r_found || (w_k_q < r_hit_rank));
    assign w_take_free = r_pv && (w_e_q.count == '0) && (!r_got || (w_k_q > r_free_rank));

    assign w_is_pin  = (r_op == OP_PIN);
    assign w_sat     = (w_e_q.count == COUNT_MAX);
    assign w_zero    = (w_e_q.count == '0);
    assign w_hit_sat = (r_hit_ent.count == COUNT_MAX);

    // status to the controller
    assign o_stat.is_get     = (r_op == OP_GET);
    assign o_stat.idx_ok     = int'(r_idx) < BUFFERS;
    assign o_stat.cnt_last   = (r_cnt == LAST);
    assign o_stat.need_sweep = (r_op == OP_RELEASE) && (w_e_q.count == CNT_W'(1));

    // write port selection for both rams
    always_comb begin
        w_e_we = 1'b0;
        w_e_wa = r_cnt;
        w_e_wd = '0;
        w_k_we = 1'b0;
        w_k_wa = r_cnt;
        w_k_wd = LAST - r_cnt;
        if (i_cmd.clr_wr) begin
            w_e_we = 1'b1;
            w_k_we = 1'b1;
        end else begin
            // rank sweep: bump ranks below the old one, released entry to front
            if (r_sv) begin
                w_k_we = 1'b1;
                w_k_wa = r_sa;
                if (r_sa == w_idx_a) begin
                    w_k_wd = '0;
                end else if (w_k_q < r_old_rank) begin
                    w_k_wd = w_k_q + IW'(1);
                end else begin
                    w_k_wd = w_k_q;
                end
            end
            // get: refresh the hit or retag the free entry
            if (i_cmd.get_commit) begin
                if (r_found) begin
                    w_e_we       = 1'b1;
                    w_e_wa       = r_hit_idx;
                    w_e_wd       = r_hit_ent;
                    w_e_wd.valid = 1'b1;
                    if (!w_hit_sat) begin
                        w_e_wd.count = r_hit_ent.count + CNT_W'(1);
                    end
                end else if (r_got) begin
                    w_e_we       = 1'b1;
                    w_e_wa       = r_free_idx;
                    w_e_wd.dev   = r_dev;
                    w_e_wd.blk   = r_blk;
                    w_e_wd.valid = 1'b1;
                    w_e_wd.count = CNT_W'(1);
                end
            end
            // release, pin, unpin
            if (i_cmd.ent_commit) begin
                w_e_wa = w_idx_a;
                w_e_wd = w_e_q;
                if (w_is_pin) begin
                    w_e_we       = !w_sat;
                    w_e_wd.count = w_e_q.count + CNT_W'(1);
                end else begin
                    w_e_we       = !w_zero;
                    w_e_wd.count = w_e_q.count - CNT_W'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_sv    <= 1'b0;
            r_found <= 1'b0;
            r_got   <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_rd;
            r_sv <= i_cmd.sweep_rd;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_wr || i_cmd.scan_rd || i_cmd.sweep_rd) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + IW'(1);
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_got   <= 1'b0;
            end else begin
                if (w_take_hit) begin
                    r_found <= 1'b1;
                end
                if (w_take_free) begin
                    r_got <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pa <= r_cnt;
        r_sa <= r_cnt;
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_dev <= i_device;
            r_blk <= i_block_number;
            r_idx <= i_buffer_index;
        end
        if (w_take_hit) begin
            r_hit_idx  <= r_pa;
            r_hit_rank <= w_k_q;
            r_hit_ent  <= w_e_q;
        end
        if (w_take_free) begin
            r_free_idx  <= r_pa;
            r_free_rank <= w_k_q;
        end
        if (i_cmd.ent_commit) begin
            r_old_rank <= w_k_q;
        end
        // result beat
        if (i_cmd.get_commit) begin
            if (r_found) begin
                r_res_idx <= IDX_W'(r_hit_idx);
                r_res_hit <= 1'b1;
                r_res_rd  <= !r_hit_ent.valid;
                r_res_st  <= w_hit_sat ? ST_OVER : ST_OK;
            end else if (r_got) begin
                r_res_idx <= IDX_W'(r_free_idx);
                r_res_hit <= 1'b0;
                r_res_rd  <= 1'b1;
                r_res_st  <= ST_OK;
            end else begin
                r_res_idx <= '0;
                r_res_hit <= 1'b0;
                r_res_rd  <= 1'b0;
                r_res_st  <= ST_NOFREE;
            end
        end else if (i_cmd.ent_commit) begin
            r_res_idx <= r_idx;
            r_res_hit <= 1'b0;
            r_res_rd  <= 1'b0;
            if (w_is_pin) begin
                r_res_st <= w_sat ? ST_OVER : ST_OK;
            end else begin
                r_res_st <= w_zero ? ST_UNDER : ST_OK;
            end
        end else if (i_cmd.res_pass) begin
            r_res_idx <= r_idx;
            r_res_hit <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_st  <= ST_OK;
        end
    end

    // tag, valid and count store
    bbc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (BUFFERS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (w_e_wa),
        .i_wdata (w_e_wd),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_e_q)
    );

    // recency rank store
    bbc_ram #(
        .WIDTH (IW),
        .DEPTH (BUFFERS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_k_we),
        .i_waddr (w_k_wa),
        .i_wdata (w_k_wd),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_k_q)
    );

    assign o_granted_index = r_res_idx;
    assign o_was_hit       = r_res_hit;
    assign o_need_read     = r_res_rd;
    assign o_status        = r_res_st;

endmodule

`default_nettype wire

// ===== hw/rtl/block_buffer_cache_lru.sv =====
// top level of the lru block buffer cache directory
//
//  channel | dir | beat contents
//  i_in    | in  | opcode, device, block_number, buffer_index
//  o_out   | out | granted_index, was_hit, need_read, status
//
// get: paced by the one-entry-a-cycle tag scan over the ram.
// release that frees a buffer: also runs the rank sweep over the rank ram.
// other release, pin, unpin: one entry read and update; out-of-range index: passed through.
// after reset a clearing pass over all BUFFERS entries runs before the first beat is taken.
// a result waits in the output register; the next beat is taken meanwhile and its
// result is held back until the output register is free.
`default_nettype none

module block_buffer_cache_lru import bbc_pkg::*; #(
    parameter int BUFFERS = BUFFERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bbc_in_if.sink     i_in,
    bbc_out_if.source  o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // storage and compare
    bbc_dpath #(
        .BUFFERS (BUFFERS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_opcode        (i_in.opcode),
        .i_device        (i_in.device),
        .i_block_number  (i_in.block_number),
        .i_buffer_index  (i_in.buffer_index),
        .o_granted_index (o_out.granted_index),
        .o_was_hit       (o_out.was_hit),
        .o_need_read     (o_out.need_read),
        .o_status        (o_out.status)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_block_buffer_cache_lru.sv =====
// self-checking testbench for the lru block buffer cache directory
`timescale 1ns / 100ps

module tb_block_buffer_cache_lru;
    import bbc_pkg::*;

    localparam int BUFFERS      = BUFFERS_DEF;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int HOLD_OFF     = 600;
    localparam int HOLD_OFF_AT  = 200;
    localparam int TAG_POOL     = 10;
    localparam int DIRECTED_LEN = 20;

    // one request beat
    typedef struct packed {
        t_op              opcode;
        logic [DEV_W-1:0] device;
        logic [BLK_W-1:0] block_number;
        logic [IDX_W-1:0] buffer_index;
    } t_request;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic             was_hit;
        logic             need_read;
        t_status          status;
    } t_grant;

    // directed row: request, and the result where it is fixed by hand
    typedef struct packed {
        t_request req;
        logic     typed;
        t_grant   grant;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbc_in_if  req_ch ();
    bbc_out_if grant_ch ();

    block_buffer_cache_lru #(
        .BUFFERS (BUFFERS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (grant_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // directory as the testbench sees it
    logic [DEV_W-1:0] dir_dev   [BUFFERS];
    logic [BLK_W-1:0] dir_blk   [BUFFERS];
    logic             dir_valid [BUFFERS];
    logic [CNT_W-1:0] dir_count [BUFFERS];
    logic [IDX_W-1:0] dir_rank  [BUFFERS];

    // tags that come back often, so that gets hit
    logic [DEV_W-1:0] pool_dev [TAG_POOL];
    logic [BLK_W-1:0] pool_blk [TAG_POOL];

    t_grant pending_grants [$];
    int     items_sent     = 0;
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     sender_burst   = 1'b0;

    t_step_row directed_rows [DIRECTED_LEN] = '{
        // count at zero after reset: release and unpin underflow
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_UNDER}},
        '{'{OP_UNPIN,   8'hff, 32'hffff_ffff, 5'd31}, 1'b1, '{5'd31, 1'b0, 1'b0, ST_UNDER}},
        // pin and unpin move the count only
        '{'{OP_PIN,     8'h00, 32'h0000_0000, 5'd5},  1'b1, '{5'd5,  1'b0, 1'b0, ST_OK}},
        '{'{OP_UNPIN,   8'h00, 32'h0000_0000, 5'd5},  1'b1, '{5'd5,  1'b0, 1'b0, ST_OK}},
        // every entry holds the zero tag after reset: hit on rank 0, not yet valid
        '{'{OP_GET,     8'h00, 32'h0000_0000, 5'd17}, 1'b1, '{5'd31, 1'b1, 1'b1, ST_OK}},
        // miss takes the least recent free entry, then hits it valid
        '{'{OP_GET,     8'hff, 32'hffff_ffff, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b1, ST_OK}},
        '{'{OP_GET,     8'hff, 32'hffff_ffff, 5'd31}, 1'b1, '{5'd0,  1'b1, 1'b0, ST_OK}},
        '{'{OP_PIN,     8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_OK}},
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_OK}},
        '{'{OP_UNPIN,   8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_OK}},
        // last release frees the buffer and makes it most recent
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_OK}},
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0},  1'b1, '{5'd0,  1'b0, 1'b0, ST_UNDER}},
        // rank order after the promotion
        '{'{OP_GET,     8'h5a, 32'ha5a5_5a5a, 5'd10}, 1'b0, '0},
        '{'{OP_GET,     8'h00, 32'h0000_0000, 5'd3},  1'b0, '0},
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31}, 1'b0, '0},
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31}, 1'b0, '0},
        '{'{OP_GET,     8'h00, 32'h0000_0000, 5'd7},  1'b0, '0},
        '{'{OP_GET,     8'h01, 32'h8000_0000, 5'd21}, 1'b0, '0},
        '{'{OP_PIN,     8'h00, 32'h0000_0000, 5'd31}, 1'b0, '0},
        '{'{OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1},  1'b0, '0}
    };

    // works out the result of one request and updates the directory
    function automatic t_grant apply_to_directory(t_request r);
        t_grant           g;
        bit               found;
        bit               got;
        int               pick;
        logic [IDX_W-1:0] old_rank;
        g.granted_index = r.buffer_index;
        g.was_hit       = 1'b0;
        g.need_read     = 1'b0;
        g.status        = ST_OK;
        found           = 1'b0;
        got             = 1'b0;
        pick            = 0;
        if (r.opcode == OP_GET) begin
            // lowest-rank tag match
            for (int i = 0; i < BUFFERS; i++) begin
                if (dir_dev[i] == r.device && dir_blk[i] == r.block_number &&
                    (!found || dir_rank[i] < dir_rank[pick])) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                if (dir_count[pick] == COUNT_MAX)
                    g.status = ST_OVER;
                else
                    dir_count[pick] = dir_count[pick] + CNT_W'(1);
            end else begin
                // least recent buffer with no references
                for (int i = 0; i < BUFFERS; i++) begin
                    if (dir_count[i] == '0 && (!got || dir_rank[i] > dir_rank[pick])) begin
                        pick = i;
                        got  = 1'b1;
                    end
                end
                if (!got) begin
                    g.granted_index = '0;
                    g.status        = ST_NOFREE;
                    return g;
                end
                dir_dev[pick]   = r.device;
                dir_blk[pick]   = r.block_number;
                dir_valid[pick] = 1'b0;
                dir_count[pick] = CNT_W'(1);
            end
            g.granted_index = IDX_W'(pick);
            g.was_hit       = found;
            g.need_read     = !dir_valid[pick];
            dir_valid[pick] = 1'b1;
            return g;
        end
        pick = int'(r.buffer_index);
        if (pick >= BUFFERS)
            return g;
        if (r.opcode == OP_PIN) begin
            if (dir_count[pick] == COUNT_MAX)
                g.status = ST_OVER;
            else
                dir_count[pick] = dir_count[pick] + CNT_W'(1);
            return g;
        end
        // release or unpin
        if (dir_count[pick] == '0) begin
            g.status = ST_UNDER;
            return g;
        end
        dir_count[pick] = dir_count[pick] - CNT_W'(1);
        if (r.opcode == OP_RELEASE && dir_count[pick] == '0) begin
            old_rank = dir_rank[pick];
            for (int i = 0; i < BUFFERS; i++)
                if (dir_rank[i] < old_rank)
                    dir_rank[i] = dir_rank[i] + IDX_W'(1);
            dir_rank[pick] = '0;
        end
        return g;
    endfunction

    // get for a pooled or a fresh tag
    function automatic t_request get_request(bit from_pool);
        t_request r;
        int       p;
        p              = $urandom_range(0, TAG_POOL - 1);
        r.opcode       = OP_GET;
        r.device       = from_pool ? pool_dev[p] : DEV_W'($urandom_range(0, 255));
        r.block_number = from_pool ? pool_blk[p] : BLK_W'($urandom);
        r.buffer_index = IDX_W'($urandom_range(0, BUFFERS - 1));
        return r;
    endfunction

    // release, pin or unpin, mostly on a buffer that holds references
    function automatic t_request index_request(t_op op);
        t_request r;
        int       k;
        k = $urandom_range(0, BUFFERS - 1);
        if ($urandom_range(0, 4) != 0)
            for (int tries = 0; tries < 16 && dir_count[k] == '0; tries++)
                k = $urandom_range(0, BUFFERS - 1);
        r.opcode       = op;
        r.device       = DEV_W'($urandom_range(0, 255));
        r.block_number = BLK_W'($urandom);
        r.buffer_index = IDX_W'(k);
        return r;
    endfunction

    function automatic t_request random_request();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            return get_request($urandom_range(0, 9) < 7);
        if (pick < 15)
            return index_request(OP_RELEASE);
        if (pick < 17)
            return index_request(OP_PIN);
        return index_request(OP_UNPIN);
    endfunction

    // drives one beat, waits for it to be taken and queues its result
    task automatic offer_request(input t_request r, input logic typed, input t_grant typed_grant,
                                 output t_grant predicted);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= r.opcode;
        req_ch.device       <= r.device;
        req_ch.block_number <= r.block_number;
        req_ch.buffer_index <= r.buffer_index;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_to_directory(r);
        pending_grants.push_back(typed ? typed_grant : predicted);
        items_sent++;
    endtask

    // releases every reference that is held, starting at a random buffer
    task automatic release_all();
        t_request r;
        t_grant   g;
        int       start;
        int       k;
        start = $urandom_range(0, BUFFERS - 1);
        for (int j = 0; j < BUFFERS; j++) begin
            k = (start + j) % BUFFERS;
            while (dir_count[k] != '0) begin
                r              = index_request(OP_RELEASE);
                r.buffer_index = IDX_W'(k);
                offer_request(r, 1'b0, '0, g);
            end
        end
    endtask

    // request side
    initial begin : stimulus
        t_request r;
        t_grant   granted;
        int       sat_idx;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_GET;
        req_ch.device       <= '0;
        req_ch.block_number <= '0;
        req_ch.buffer_index <= '0;
        for (int i = 0; i < BUFFERS; i++) begin
            dir_dev[i]   = '0;
            dir_blk[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_count[i] = '0;
            dir_rank[i]  = IDX_W'(BUFFERS - 1 - i);
        end
        for (int i = 0; i < TAG_POOL; i++) begin
            pool_dev[i] = DEV_W'($urandom_range(0, 255));
            pool_blk[i] = BLK_W'($urandom);
        end
        // the reset tag stays in the pool
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < DIRECTED_LEN; k++)
            offer_request(directed_rows[k].req, directed_rows[k].typed,
                          directed_rows[k].grant, granted);

        // take every buffer and more: the surplus finds none free
        repeat (BUFFERS + 6)
            offer_request(get_request(1'b0), 1'b0, '0, granted);
        release_all();

        // drive one count to its ceiling, overflow on pin and on a get hit, then back down
        r              = get_request(1'b1);
        r.device       = pool_dev[1];
        r.block_number = pool_blk[1];
        offer_request(r, 1'b0, '0, granted);
        sat_idx        = int'(granted.granted_index);
        r.opcode       = OP_PIN;
        r.buffer_index = IDX_W'(sat_idx);
        while (dir_count[sat_idx] != COUNT_MAX)
            offer_request(r, 1'b0, '0, granted);
        repeat (2)
            offer_request(r, 1'b0, '0, granted);
        r.opcode = OP_GET;
        offer_request(r, 1'b0, '0, granted);
        sender_burst = 1'b1;
        r.opcode     = OP_RELEASE;
        while (dir_count[sat_idx] != '0)
            offer_request(r, 1'b0, '0, granted);
        offer_request(r, 1'b0, '0, granted);

        // random episodes
        while (items_sent < ITEM_TARGET) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    repeat (BUFFERS + 6)
                        offer_request(get_request($urandom_range(0, 3) == 0), 1'b0, '0, granted);
                end
                1: release_all();
                default: begin
                    repeat (30)
                        offer_request(random_request(), 1'b0, '0, granted);
                end
            endcase
        end
        req_ch.valid <= 1'b0;

        // drain, then let a late beat show itself
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (BUFFERS + 16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, stall-free stretches and one long hold-off
    initial begin : grant_sink
        int stall;
        int beats;
        bit held_off;
        bit burst;
        beats    = 0;
        held_off = 1'b0;
        burst    = 1'b0;
        grant_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (!held_off && beats == HOLD_OFF_AT) begin
                stall    = HOLD_OFF;
                held_off = 1'b1;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                grant_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            grant_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!grant_ch.valid);
            beats++;
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : grant_check
        t_grant want;
        if (i_rst_n && grant_ch.valid && grant_ch.ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected beat: index %0d hit %0b read %0b status %0d",
                         $time, grant_ch.granted_index, grant_ch.was_hit,
                         grant_ch.need_read, grant_ch.status);
                mismatch_count++;
            end else begin
                want = pending_grants.pop_front();
                if (grant_ch.granted_index !== want.granted_index) begin
                    $display("%0t: granted_index expected %0d actual %0d",
                             $time, want.granted_index, grant_ch.granted_index);
                    mismatch_count++;
                end
                if (grant_ch.was_hit !== want.was_hit) begin
                    $display("%0t: was_hit expected %0b actual %0b",
                             $time, want.was_hit, grant_ch.was_hit);
                    mismatch_count++;
                end
                if (grant_ch.need_read !== want.need_read) begin
                    $display("%0t: need_read expected %0b actual %0b",
                             $time, want.need_read, grant_ch.need_read);
                    mismatch_count++;
                end
                if (grant_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, grant_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_grants.size());
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
